FILE: rtl/swd_pkg.sv
// Shared types, constants and the control microprogram of the stereo widener.
`default_nettype none

package swd_pkg;

    // Default sizes of the block.
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int HISTORY_DEPTH_DEF = 256;

    // Widths fixed by the register map.
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int OPB_W      = GAIN_W + 1;

    // Fixed Q3.13 coefficients: 0.56, 0.82 and 0.18.
    localparam int Q13_MID  = 4588;
    localparam int Q13_KEEP = 6717;
    localparam int Q13_MIX  = 1475;

    // Round-half-up offsets for shifts by 13 and by 14.
    localparam int RND13_VAL = 4096;
    localparam int RND14_VAL = 8192;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_SIDE   = 3'd1,
        REG_DELAY  = 3'd2,
        REG_LEFT   = 3'd3,
        REG_RIGHT  = 3'd4,
        REG_DIRECT = 3'd5,
        REG_CROSS  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic               enable;
        logic [GAIN_W-1:0]  side_gain;
        logic [DELAY_W-1:0] decor_delay;
        logic [GAIN_W-1:0]  left_gain;
        logic [GAIN_W-1:0]  right_gain;
        logic [GAIN_W-1:0]  direct_gain;
        logic [GAIN_W-1:0]  cross_gain;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enable:      1'b0,
        side_gain:   16'd19497,
        decor_delay: 8'd144,
        left_gain:   16'd8192,
        right_gain:  16'd8192,
        direct_gain: 16'd8192,
        cross_gain:  16'd0
    };

    // Sequencer state.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // Microword fields.
    typedef enum logic [2:0] {
        OPA_SUM,
        OPA_DIF,
        OPA_A,
        OPA_B,
        OPA_DL,
        OPA_DR
    } opa_sel_t;

    typedef enum logic [2:0] {
        OPB_MID,
        OPB_KEEP,
        OPB_MIX,
        OPB_SIDE,
        OPB_LEFT,
        OPB_RIGHT,
        OPB_DIRECT,
        OPB_CROSS
    } opb_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD13,
        ACC_LOAD14,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        ST_NONE,
        ST_MID,
        ST_AB,
        ST_A,
        ST_B,
        ST_LO,
        ST_OUT,
        ST_PASS
    } st_op_t;

    typedef enum logic {
        BR_NONE,
        BR_DISABLED
    } br_t;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_PASS = 5'd18;

    typedef struct packed {
        opa_sel_t          sel_a;
        opb_sel_t          sel_b;
        acc_op_t           acc_op;
        st_op_t            st_op;
        logic              rd_tap;
        logic              wr_hist;
        logic              done;
        br_t               br;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        sel_a:   OPA_SUM,
        sel_b:   OPB_MID,
        acc_op:  ACC_HOLD,
        st_op:   ST_NONE,
        rd_tap:  1'b0,
        wr_hist: 1'b0,
        done:    1'b0,
        br:      BR_NONE,
        target:  '0
    };

    // The microprogram. The product is registered, so an accumulate always
    // consumes the multiply issued by the step before it.
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = CW_NOP;
        case (step)
            5'd0: begin
                cw.sel_a  = OPA_SUM;
                cw.sel_b  = OPB_MID;
                cw.rd_tap = 1'b1;
                cw.br     = BR_DISABLED;
                cw.target = STEP_PASS;
            end
            5'd1: begin
                cw.sel_a  = OPA_DIF;
                cw.sel_b  = OPB_SIDE;
                cw.acc_op = ACC_LOAD14;
            end
            5'd2: begin
                cw.st_op  = ST_MID;
                cw.acc_op = ACC_LOAD14;
            end
            5'd3: begin
                cw.st_op = ST_AB;
            end
            5'd4: begin
                cw.sel_a = OPA_A;
                cw.sel_b = OPB_KEEP;
            end
            5'd5: begin
                cw.sel_a  = OPA_DR;
                cw.sel_b  = OPB_MIX;
                cw.acc_op = ACC_LOAD13;
            end
            5'd6: begin
                cw.sel_a  = OPA_B;
                cw.sel_b  = OPB_KEEP;
                cw.acc_op = ACC_ADD;
            end
            5'd7: begin
                cw.sel_a  = OPA_DL;
                cw.sel_b  = OPB_MIX;
                cw.acc_op = ACC_LOAD13;
                cw.st_op  = ST_A;
            end
            5'd8: begin
                cw.sel_a  = OPA_A;
                cw.sel_b  = OPB_LEFT;
                cw.acc_op = ACC_ADD;
            end
            5'd9: begin
                cw.st_op  = ST_B;
                cw.acc_op = ACC_LOAD13;
            end
            5'd10: begin
                cw.sel_a = OPA_B;
                cw.sel_b = OPB_RIGHT;
                cw.st_op = ST_A;
            end
            5'd11: begin
                cw.sel_a  = OPA_A;
                cw.sel_b  = OPB_DIRECT;
                cw.acc_op = ACC_LOAD13;
            end
            5'd12: begin
                cw.st_op  = ST_B;
                cw.acc_op = ACC_LOAD13;
            end
            5'd13: begin
                cw.sel_a = OPA_B;
                cw.sel_b = OPB_CROSS;
            end
            5'd14: begin
                cw.sel_a  = OPA_B;
                cw.sel_b  = OPB_DIRECT;
                cw.acc_op = ACC_ADD;
            end
            5'd15: begin
                cw.sel_a  = OPA_A;
                cw.sel_b  = OPB_CROSS;
                cw.st_op  = ST_LO;
                cw.acc_op = ACC_LOAD13;
            end
            5'd16: begin
                cw.acc_op = ACC_ADD;
            end
            5'd17: begin
                cw.st_op   = ST_OUT;
                cw.wr_hist = 1'b1;
                cw.done    = 1'b1;
            end
            default: begin
                cw.st_op = ST_PASS;
                cw.done  = 1'b1;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/swd_if.sv
// Stream and configuration interfaces of the stereo widener.
`default_nettype none

interface swd_in_if
    import swd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          frame_last;

    modport source (output valid, left_in, right_in, frame_last, input ready);
    modport sink   (input valid, left_in, right_in, frame_last, output ready);
    modport monitor(input valid, ready, left_in, right_in, frame_last);
endinterface

interface swd_out_if
    import swd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_end;

    modport source (output valid, left_out, right_out, block_end, input ready);
    modport sink   (input valid, left_out, right_out, block_end, output ready);
    modport monitor(input valid, ready, left_out, right_out, block_end);
endinterface

interface swd_cfg_if
    import swd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
    modport monitor(input valid, ready, index, data);
endinterface

`default_nettype wire

FILE: rtl/stereo_widen_decorrelate.sv
// Top level of the mid/side stereo widener with cross-channel decorrelation.
`default_nettype none

// The block takes one stereo pair per transfer on the sample channel and
// returns one processed pair per transfer on the result channel, in order,
// with block_end copied from frame_last. With enable set, an accepted pair
// is processed in 18 steps of the microprogram, which runs every multiply
// through a single shared 17-bit-by-(SAMPLE_BITS+8)-bit multiplier with a
// registered product. The sequencer then returns to idle to take the next
// pair. With enable clear the pair is passed through unchanged, and the
// history is left untouched. The final step stalls for as long as the
// output register holds a result that is not being taken. A new pair is
// accepted as soon as the previous result has moved into the output
// register, even if that result has not yet been taken. The history holds
// HISTORY_DEPTH pairs; no clearing pass is needed after reset, because
// entries are written in pointer order and an entry not yet written reads
// as zero. Configuration registers are written through the cfg channel,
// which is always ready; they should be changed only while the block is
// idle.

module stereo_widen_decorrelate
    import swd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    swd_in_if.sink    sample,
    swd_out_if.source result,
    swd_cfg_if.sink   cfg
);

    cfg_t              cfg_reg, cfg_next;
    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_left_reg, out_right_reg;
    logic              out_last_reg;
    logic              last_reg;

    ctrl_word_t        cw;
    logic              accept;
    logic              out_free;
    logic              step_en;
    logic signed [SAMPLE_BITS-1:0] res_left, res_right;

    // Configuration writes are always taken; an index past the list is ignored.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid) begin
            case (cfg.index)
                REG_ENABLE: cfg_next.enable      = cfg.data[0];
                REG_SIDE:   cfg_next.side_gain   = cfg.data[GAIN_W-1:0];
                REG_DELAY:  cfg_next.decor_delay = cfg.data[DELAY_W-1:0];
                REG_LEFT:   cfg_next.left_gain   = cfg.data[GAIN_W-1:0];
                REG_RIGHT:  cfg_next.right_gain  = cfg.data[GAIN_W-1:0];
                REG_DIRECT: cfg_next.direct_gain = cfg.data[GAIN_W-1:0];
                REG_CROSS:  cfg_next.cross_gain  = cfg.data[GAIN_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // The current microword comes straight from the program table.
    assign cw = ucode(step_reg);

    // The output register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || result.ready;
    assign accept   = sample.valid && sample.ready;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (sample.valid) begin
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if (cw.done && out_free) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // Outputs of the sequencer. The final step stalls until its result can
    // be placed in the output register.
    always_comb
    begin
        sample.ready = 1'b0;
        step_en      = 1'b0;
        case (state_reg)
            SEQ_IDLE: sample.ready = 1'b1;
            SEQ_RUN:  step_en      = !cw.done || out_free;
            default:  step_en      = 1'b0;
        endcase
    end

    // Step counter with the bypass branch taken when processing is off.
    always_comb
    begin
        step_next = step_reg;
        if (state_reg == SEQ_IDLE) begin
            step_next = '0;
        end else if (step_en) begin
            if (cw.br == BR_DISABLED && !cfg_reg.enable) begin
                step_next = cw.target;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_en && cw.done) begin
            out_valid_next = 1'b1;
        end else if (result.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg       <= CFG_RESET;
            state_reg     <= SEQ_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            last_reg <= sample.frame_last;
        end
        if (step_en && cw.done) begin
            out_left_reg  <= res_left;
            out_right_reg <= res_right;
            out_last_reg  <= last_reg;
        end
    end

    swd_datapath #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .left_in  (sample.left_in),
        .right_in (sample.right_in),
        .cfg      (cfg_reg),
        .cw       (cw),
        .step_en  (step_en),
        .res_left (res_left),
        .res_right(res_right)
    );

    assign result.valid     = out_valid_reg;
    assign result.left_out  = out_left_reg;
    assign result.right_out = out_right_reg;
    assign result.block_end = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/swd_datapath.sv
// Shared-multiplier datapath and delay-line history of the stereo widener.
`default_nettype none

module swd_datapath
    import swd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    input  cfg_t                          cfg,
    input  ctrl_word_t                    cw,
    input  logic                          step_en,
    output logic signed [SAMPLE_BITS-1:0] res_left,
    output logic signed [SAMPLE_BITS-1:0] res_right
);

    localparam int PTR_W   = $clog2(HISTORY_DEPTH);
    localparam int OPA_W   = SAMPLE_BITS + 8;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int ENTRY_W = 2 * SAMPLE_BITS;
    localparam int DELAY_N = 2 ** DELAY_W;

    localparam logic signed [ACC_W-1:0] RND13  = ACC_W'(RND13_VAL);
    localparam logic signed [ACC_W-1:0] RND14  = ACC_W'(RND14_VAL);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_s(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end
        if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

    logic signed [SAMPLE_BITS-1:0] l_reg, r_reg;
    logic signed [OPA_W-1:0]       mid_reg, a_reg, b_reg;
    logic signed [OPA_W-1:0]       mid_next, a_next, b_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic [PTR_W-1:0]              wp_reg, wp_next;
    logic                          full_reg, full_next;
    logic [ENTRY_W-1:0]            tap_data_reg;
    logic                          tap_ok_reg;

    logic [ENTRY_W-1:0]            hist_mem [HISTORY_DEPTH];

    logic [PTR_W-1:0]              dmod_tab [DELAY_N];
    logic [PTR_W-1:0]              dmod;
    logic [PTR_W-1:0]              tap_addr;
    logic                          tap_ok;

    logic signed [OPA_W-1:0]       l_ext, r_ext, dl_ext, dr_ext, opa;
    logic signed [OPB_W-1:0]       opb;
    logic signed [ACC_W-1:0]       sh13, sh14;
    logic signed [OPA_W-1:0]       side;

    // Delay reduced modulo the history depth.
    genvar gi;
    generate
        for (gi = 0; gi < DELAY_N; gi++) begin : g_dmod
            assign dmod_tab[gi] = PTR_W'(gi % HISTORY_DEPTH);
        end
    endgenerate

    assign dmod = dmod_tab[cfg.decor_delay];

    // Entries are written in pointer order from zero, so an entry holds data
    // once the pointer has passed it or wrapped; anything else reads as zero.
    always_comb
    begin
        if (wp_reg >= dmod) begin
            tap_addr = wp_reg - dmod;
        end else begin
            tap_addr = PTR_W'({1'b0, wp_reg} + (PTR_W + 1)'(HISTORY_DEPTH) - {1'b0, dmod});
        end
        tap_ok = full_reg || (tap_addr < wp_reg);
    end

    assign l_ext  = OPA_W'(l_reg);
    assign r_ext  = OPA_W'(r_reg);
    assign dl_ext = tap_ok_reg ? OPA_W'($signed(tap_data_reg[ENTRY_W-1:SAMPLE_BITS])) : '0;
    assign dr_ext = tap_ok_reg ? OPA_W'($signed(tap_data_reg[SAMPLE_BITS-1:0])) : '0;

    always_comb
    begin
        case (cw.sel_a)
            OPA_SUM: opa = l_ext + r_ext;
            OPA_DIF: opa = l_ext - r_ext;
            OPA_A:   opa = a_reg;
            OPA_B:   opa = b_reg;
            OPA_DL:  opa = dl_ext;
            OPA_DR:  opa = dr_ext;
            default: opa = '0;
        endcase
    end

    always_comb
    begin
        case (cw.sel_b)
            OPB_MID:    opb = OPB_W'(Q13_MID);
            OPB_KEEP:   opb = OPB_W'(Q13_KEEP);
            OPB_MIX:    opb = OPB_W'(Q13_MIX);
            OPB_SIDE:   opb = $signed({1'b0, cfg.side_gain});
            OPB_LEFT:   opb = $signed({1'b0, cfg.left_gain});
            OPB_RIGHT:  opb = $signed({1'b0, cfg.right_gain});
            OPB_DIRECT: opb = $signed({1'b0, cfg.direct_gain});
            OPB_CROSS:  opb = $signed({1'b0, cfg.cross_gain});
            default:    opb = '0;
        endcase
    end

    assign prod_next = PROD_W'(opa) * PROD_W'(opb);

    assign sh13 = acc_reg >>> 13;
    assign sh14 = acc_reg >>> 14;
    assign side = OPA_W'(sh14);

    always_comb
    begin
        case (cw.acc_op)
            ACC_LOAD13: acc_next = ACC_W'(prod_reg) + RND13;
            ACC_LOAD14: acc_next = ACC_W'(prod_reg) + RND14;
            ACC_ADD:    acc_next = acc_reg + ACC_W'(prod_reg);
            default:    acc_next = acc_reg;
        endcase
    end

    always_comb
    begin
        mid_next = mid_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        case (cw.st_op)
            ST_MID: mid_next = side;
            ST_AB:
            begin
                a_next = mid_reg + side;
                b_next = mid_reg - side;
            end
            ST_A:   a_next   = OPA_W'(sh13);
            ST_B:   b_next   = OPA_W'(sh13);
            ST_LO:  mid_next = OPA_W'(sat_s(sh13));
            default:
            begin
                mid_next = mid_reg;
            end
        endcase
    end

    always_comb
    begin
        if (cw.st_op == ST_PASS) begin
            res_left  = l_reg;
            res_right = r_reg;
        end else begin
            res_left  = mid_reg[SAMPLE_BITS-1:0];
            res_right = sat_s(sh13);
        end
    end

    always_comb
    begin
        wp_next   = wp_reg;
        full_next = full_reg;
        if (step_en && cw.wr_hist) begin
            if (wp_reg == PTR_W'(HISTORY_DEPTH - 1)) begin
                wp_next   = '0;
                full_next = 1'b1;
            end else begin
                wp_next = wp_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg     <= '0;
            full_reg   <= 1'b0;
            tap_ok_reg <= 1'b0;
        end else begin
            wp_reg   <= wp_next;
            full_reg <= full_next;
            if (step_en && cw.rd_tap) begin
                tap_ok_reg <= tap_ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            l_reg <= left_in;
            r_reg <= right_in;
        end
        if (step_en) begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            mid_reg  <= mid_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && cw.wr_hist) begin
            hist_mem[wp_reg] <= {l_reg, r_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && cw.rd_tap) begin
            tap_data_reg <= hist_mem[tap_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/swd_checker.sv
// Port-level assertions for the stereo widener and their bind to the top level.
`default_nettype none

module swd_checker (
    input logic       clk,
    input logic       rst_n,
    swd_in_if.sink    sample,
    swd_out_if.source result
);

    // A pending result stays offered until it is taken.
    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> result.valid)
        else $error("result valid dropped before its transfer");

    // The frame marker of a pending result does not change under a stall.
    a_out_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(result.block_end))
        else $error("block_end changed while the result was stalled");

    // The block works on one pair at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("sample accepted while a pair was still in work");

    // No result can appear in the cycle right after a sample transfer.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !$rose(result.valid))
        else $error("result appeared too early after a sample transfer");

    // A new result is only produced while a pair was in work.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> !$past(sample.ready))
        else $error("result appeared while the block was idle");

endmodule

bind stereo_widen_decorrelate swd_checker u_swd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .sample(sample),
    .result(result)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the mid/side stereo widener with decorrelation tap.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swd_pkg::*;

    // The block is tested at its default sizes.
    localparam int SW = SAMPLE_BITS_DEF;
    localparam int HD = HISTORY_DEPTH_DEF;

    // Fixed Q3.13 coefficients of the widener: 0.56, 0.82 and 0.18.
    localparam int MID_COEF  = 4588;
    localparam int KEEP_COEF = 6717;
    localparam int MIX_COEF  = 1475;

    // The watchdog limit lies far above any gap between transfers in a correct
    // run.
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 6;
    localparam int PHASE_PAIRS   = 80;

    localparam logic signed [SW-1:0] FULL_POS = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] FULL_NEG = {1'b1, {(SW-1){1'b0}}};

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 last;
    } stereo_pair_t;

    logic clk;
    logic rst_n;

    swd_in_if  #(.SAMPLE_BITS(SW)) sample_bus ();
    swd_out_if #(.SAMPLE_BITS(SW)) result_bus ();
    swd_cfg_if                     cfg_bus ();

    stereo_widen_decorrelate #(
        .SAMPLE_BITS  (SW),
        .HISTORY_DEPTH(HD)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_bus),
        .result(result_bus),
        .cfg   (cfg_bus)
    );

    // Shadow copy of the register file, updated on every configuration transfer.
    cfg_t mirror_cfg;

    // Shadow copy of the sample history and its write pointer.
    logic signed [SW-1:0] echo_left  [HD];
    logic signed [SW-1:0] echo_right [HD];
    int                   echo_ptr;

    // Widened pairs that the block still owes us, oldest first.
    stereo_pair_t pending_pairs [$];
    stereo_pair_t oldest;

    int errors;
    bit no_idle;

    // Clock generation: 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Multiply-and-shift rounding: add half an LSB, then shift toward minus
    // infinity. The arithmetic shift of a signed value gives exactly that floor.
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Only the final outputs are clamped to the signed sample range.
    function automatic logic signed [SW-1:0] clamp_sample(input longint v);
        if (v > longint'(FULL_POS))
            return FULL_POS;
        if (v < longint'(FULL_NEG))
            return FULL_NEG;
        return v[SW-1:0];
    endfunction

    // Computes the widened output for one accepted pair and advances the
    // shadow history exactly as the block does. With processing disabled the
    // pair comes back unchanged and the history is left alone.
    function automatic stereo_pair_t widen_pair(input logic signed [SW-1:0] l_in,
                                                input logic signed [SW-1:0] r_in,
                                                input logic last);
        stereo_pair_t res;
        longint l, r, mid, side, a, b, a2, b2, a3, b3, lo, ro, dl, dr;
        int tap;
        res.last = last;
        if (!mirror_cfg.enable)
        begin
            res.left  = l_in;
            res.right = r_in;
            return res;
        end
        l = l_in;
        r = r_in;
        // The halving of mid and side is folded into the shift by 14.
        mid  = round_half_up((l + r) * MID_COEF, 14);
        side = round_half_up((l - r) * longint'(mirror_cfg.side_gain), 14);
        a = mid + side;
        b = mid - side;
        // The tap is read before the current pair is stored. A delay of zero
        // lands on the write slot itself, which holds the oldest pair.
        tap = (echo_ptr + HD - (int'(mirror_cfg.decor_delay) % HD)) % HD;
        dl  = echo_left[tap];
        dr  = echo_right[tap];
        // Each channel keeps 0.82 of itself and takes 0.18 of the other
        // channel's delayed raw input.
        a2 = round_half_up(a * KEEP_COEF + dr * MIX_COEF, 13);
        b2 = round_half_up(b * KEEP_COEF + dl * MIX_COEF, 13);
        a3 = round_half_up(a2 * longint'(mirror_cfg.left_gain), 13);
        b3 = round_half_up(b2 * longint'(mirror_cfg.right_gain), 13);
        lo = round_half_up(a3 * longint'(mirror_cfg.direct_gain)
                           + b3 * longint'(mirror_cfg.cross_gain), 13);
        ro = round_half_up(b3 * longint'(mirror_cfg.direct_gain)
                           + a3 * longint'(mirror_cfg.cross_gain), 13);
        echo_left[echo_ptr]  = l_in;
        echo_right[echo_ptr] = r_in;
        echo_ptr = (echo_ptr + 1) % HD;
        res.left  = clamp_sample(lo);
        res.right = clamp_sample(ro);
        return res;
    endfunction

    // Random sample: mostly full range, with the two extremes and values
    // near zero mixed in so that rounding around zero is exercised too.
    function automatic logic signed [SW-1:0] pick_sample();
        logic [31:0] raw;
        int          near_zero;
        raw       = $urandom();
        near_zero = int'($urandom_range(0, 4000)) - 2000;
        case ($urandom_range(0, 7))
            0:       return FULL_POS;
            1:       return FULL_NEG;
            2:       return near_zero[SW-1:0];
            default: return raw[SW-1:0];
        endcase
    endfunction

    // Random Q3.13 gain. Gains near unity keep most outputs out of
    // saturation; zero, full scale and fully random values cover the rest.
    function automatic logic [GAIN_W-1:0] pick_gain();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'(8192);
            3, 4, 5,
            6:       return GAIN_W'($urandom_range(4096, 12288));
            default: return raw[GAIN_W-1:0];
        endcase
    endfunction

    // Writes one register and mirrors the write in the shadow copy at the
    // moment of the transfer.
    task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_ENABLE: mirror_cfg.enable      = value[0];
            REG_SIDE:   mirror_cfg.side_gain   = value[GAIN_W-1:0];
            REG_DELAY:  mirror_cfg.decor_delay = value[DELAY_W-1:0];
            REG_LEFT:   mirror_cfg.left_gain   = value[GAIN_W-1:0];
            REG_RIGHT:  mirror_cfg.right_gain  = value[GAIN_W-1:0];
            REG_DIRECT: mirror_cfg.direct_gain = value[GAIN_W-1:0];
            REG_CROSS:  mirror_cfg.cross_gain  = value[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Offers one pair on the sample channel, sometimes after a short idle
    // burst, and records its expected result once the transfer happens.
    // Valid is left high so that back-to-back pairs need no extra cycle.
    task automatic send_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                             input logic last);
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            sample_bus.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        sample_bus.valid      = 1'b1;
        sample_bus.left_in    = l;
        sample_bus.right_in   = r;
        sample_bus.frame_last = last;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        pending_pairs.push_back(widen_pair(l, r, last));
    endtask

    // Stops offering pairs and waits until every owed result has been taken,
    // which leaves the block idle and safe to reconfigure.
    task automatic wait_for_results();
        @(negedge clk);
        sample_bus.valid = 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
    endtask

    // Pass-through right after reset: the block comes up disabled, so the
    // extremes must come back untouched with frame_last copied.
    task automatic test_pass_through();
        send_pair(FULL_POS, FULL_NEG, 1'b1);
        send_pair(FULL_NEG, FULL_POS, 1'b0);
        send_pair('0, '1, 1'b1);
        send_pair('1, '0, 1'b0);
        send_pair(pick_sample(), pick_sample(), 1'b1);
    endtask

    // Processing with the reset gains. The history has not been written yet,
    // so the decorrelation tap contributes zero.
    task automatic test_default_gains();
        wait_for_results();
        cfg_write(REG_ENABLE, CFG_DATA_W'(1));
        send_pair(FULL_POS, FULL_POS, 1'b0);
        send_pair(FULL_NEG, FULL_NEG, 1'b1);
        send_pair(FULL_POS, FULL_NEG, 1'b0);
        send_pair(FULL_NEG, FULL_POS, 1'b1);
        send_pair('0, '0, 1'b0);
        send_pair(SW'(1), '1, 1'b1);
    endtask

    // Tap distances at the edges: one pair back, zero (the slot about to be
    // written), and the largest delay the register holds.
    task automatic test_short_delays();
        wait_for_results();
        cfg_write(REG_DELAY, CFG_DATA_W'(1));
        send_pair(FULL_POS, FULL_NEG, 1'b0);
        send_pair(FULL_NEG, FULL_POS, 1'b0);
        send_pair(pick_sample(), pick_sample(), 1'b1);
        wait_for_results();
        cfg_write(REG_DELAY, CFG_DATA_W'(0));
        send_pair(pick_sample(), pick_sample(), 1'b0);
        send_pair(FULL_POS, FULL_POS, 1'b1);
        wait_for_results();
        cfg_write(REG_DELAY, CFG_DATA_W'(255));
        send_pair(FULL_NEG, FULL_NEG, 1'b0);
        send_pair(pick_sample(), pick_sample(), 1'b1);
    endtask

    // Every gain at full scale drives the outputs hard into both saturation
    // limits; every gain at zero must then give silence.
    task automatic test_saturation();
        wait_for_results();
        cfg_write(REG_SIDE, '1);
        cfg_write(REG_LEFT, '1);
        cfg_write(REG_RIGHT, '1);
        cfg_write(REG_DIRECT, '1);
        cfg_write(REG_CROSS, '1);
        send_pair(FULL_POS, FULL_NEG, 1'b0);
        send_pair(FULL_NEG, FULL_POS, 1'b1);
        send_pair(FULL_POS, FULL_POS, 1'b0);
        send_pair(FULL_NEG, FULL_NEG, 1'b1);
        wait_for_results();
        cfg_write(REG_SIDE, '0);
        cfg_write(REG_LEFT, '0);
        cfg_write(REG_RIGHT, '0);
        cfg_write(REG_DIRECT, '0);
        cfg_write(REG_CROSS, '0);
        send_pair(FULL_POS, FULL_NEG, 1'b1);
    endtask

    // Random streams under a fresh random setting per phase. Phase 1 runs
    // disabled so that the history must survive a pass-through stretch;
    // phases 2, 3 and 4 use delays of one, zero and the maximum. The last
    // phase runs with no idling at all.
    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] delay_val;
        logic                  en;
        logic signed [SW-1:0]  l, r;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_for_results();
            if (phase == PHASES - 1)
                no_idle = 1'b1;
            en = (phase == 1) ? 1'b0 : (phase == PHASES - 1) ? 1'b1 : ($urandom_range(0, 5) != 0);
            case (phase)
                2:       delay_val = CFG_DATA_W'(1);
                3:       delay_val = CFG_DATA_W'(0);
                4:       delay_val = CFG_DATA_W'(255);
                default: delay_val = CFG_DATA_W'($urandom_range(1, 255));
            endcase
            cfg_write(REG_ENABLE, CFG_DATA_W'(en));
            cfg_write(REG_DELAY, delay_val);
            cfg_write(REG_SIDE, pick_gain());
            cfg_write(REG_LEFT, pick_gain());
            cfg_write(REG_RIGHT, pick_gain());
            cfg_write(REG_DIRECT, pick_gain());
            cfg_write(REG_CROSS, pick_gain());
            for (int n = 0; n < PHASE_PAIRS; n++)
            begin
                l = pick_sample();
                // Some pairs are pure mid or pure side content.
                case ($urandom_range(0, 5))
                    0:       r = l;
                    1:       r = -l;
                    default: r = pick_sample();
                endcase
                send_pair(l, r, $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // Result side: ready drops for random bursts, except in the final stretch
    // of the run.
    initial
    begin : result_ready_gen
        int hold;
        hold = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (no_idle)
                hold = 0;
            else if (hold == 0 && $urandom_range(0, 3) == 0)
                hold = $urandom_range(1, 8);
            if (hold > 0)
            begin
                result_bus.ready = 1'b0;
                hold--;
            end
            else
                result_bus.ready = 1'b1;
        end
    end

    // Every result transfer is compared field by field with the oldest
    // expected pair. A result with nothing owed is an error on its own.
    always @(posedge clk)
    begin
        if (result_bus.valid && result_bus.ready)
        begin
            if (pending_pairs.size() == 0)
            begin
                $display("%0t result with nothing expected: left %0d right %0d end %0b",
                         $time, result_bus.left_out, result_bus.right_out,
                         result_bus.block_end);
                errors++;
            end
            else
            begin
                oldest = pending_pairs.pop_front();
                if (result_bus.left_out !== oldest.left)
                begin
                    $display("%0t left_out mismatch: expected %0d, actual %0d",
                             $time, oldest.left, result_bus.left_out);
                    errors++;
                end
                if (result_bus.right_out !== oldest.right)
                begin
                    $display("%0t right_out mismatch: expected %0d, actual %0d",
                             $time, oldest.right, result_bus.right_out);
                    errors++;
                end
                if (result_bus.block_end !== oldest.last)
                begin
                    $display("%0t block_end mismatch: expected %0b, actual %0b",
                             $time, oldest.last, result_bus.block_end);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a hang shows up as a long run of cycles with no transfer on
    // any of the three channels.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Main sequence: reset once, run each test in turn, then let the block
    // settle so that any stray extra result would still be caught.
    initial
    begin
        errors   = 0;
        no_idle  = 1'b0;
        echo_ptr = 0;
        for (int i = 0; i < HD; i++)
        begin
            echo_left[i]  = '0;
            echo_right[i] = '0;
        end
        mirror_cfg = '{
            enable:      1'b0,
            side_gain:   16'd19497,
            decor_delay: 8'd144,
            left_gain:   16'd8192,
            right_gain:  16'd8192,
            direct_gain: 16'd8192,
            cross_gain:  16'd0
        };
        rst_n                 = 1'b0;
        sample_bus.valid      = 1'b0;
        sample_bus.left_in    = '0;
        sample_bus.right_in   = '0;
        sample_bus.frame_last = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = REG_ENABLE;
        cfg_bus.data          = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pass_through();
        test_default_gains();
        test_short_delays();
        test_saturation();
        test_random_phases();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
